@@ src/rsm_pkg.sv @@
// Shared types and constants for the receive slot manager.
// No dependencies; imported by receive_slot_manager_top.
package rsm_pkg;

	localparam int MODE_W   = 2;
	localparam int LEN_W    = 22;
	localparam int OFF_W    = 26;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 7;
	localparam int SORD_W   = 3;
	localparam int MORD_W   = 5;
	localparam int CFG_W    = 5;
	localparam int CIDX_W   = 1;

	// slot size never grows past 2^20 bytes
	localparam logic [MORD_W-1:0] MORD_CAP   = 5'd20;
	localparam logic [MORD_W-1:0] MORD_RESET = 5'd6;

	typedef enum logic [MODE_W-1:0] {
		MODE_ARRIVE = 2'd0,
		MODE_FETCH  = 2'd1,
		MODE_ACK    = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_MSG    = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_SLOT_ORDER    = 1'd0,
		REG_MESSAGE_ORDER = 1'd1
	} reg_idx_t;

endpackage

@@ src/receive_slot_manager_top.sv @@
// Receive slot manager: slot bitmaps, unread count and search positions
// for one receive endpoint. Depends on rsm_pkg.
//
//  channel | signals                                  | dir | handshake
//  --------+------------------------------------------+-----+-----------------
//  in      | mode, message_length, message_offset     | in  | in_valid/in_ready
//  out     | status, slot_offset, message_count       | out | out_valid/out_ready
//  cfg     | cfg_we, cfg_index, cfg_data              | in  | write enable only
//
// One word is taken per cycle while in_ready is high; each word passes through
// the input register, then the result register. The slot search is a rotating
// priority encoder over the bitmap, done between the two registers, and the
// state updates as the result register loads, so the next word sees it.
// Reset and any configuration write clear bitmaps, count and positions.
// A stalled result register holds the input register, and in_ready drops
// only while both are full and out_ready is low.
module receive_slot_manager_top #(
	parameter int MAX_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsm_pkg::MODE_W-1:0]    mode,
	input  logic [rsm_pkg::LEN_W-1:0]     message_length,
	input  logic [rsm_pkg::OFF_W-1:0]     message_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rsm_pkg::STATUS_W-1:0]  status,
	output logic [rsm_pkg::OFF_W-1:0]     slot_offset,
	output logic [rsm_pkg::CNT_W-1:0]     message_count,
	input  logic                          cfg_we,
	input  logic [rsm_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [rsm_pkg::CFG_W-1:0]     cfg_data
);
	import rsm_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int POS_W = $clog2(MAX_SLOTS + 1);

	// lowest set bit of a slot mask
	function automatic logic [IDX_W-1:0] first_set(input logic [MAX_SLOTS-1:0] m);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
			if (m[j]) begin
				r = IDX_W'(j);
			end
		end
		return r;
	endfunction

	// configuration
	logic [SORD_W-1:0]    slot_order_q;
	logic [MORD_W-1:0]    message_order_q;

	// state
	logic [MAX_SLOTS-1:0] occupied_q, unread_q;
	logic [CNT_W-1:0]     count_q;
	logic [POS_W-1:0]     wpos_q, rpos_q;

	// input register
	logic                 v_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [LEN_W-1:0]     len_s1;
	logic [OFF_W-1:0]     off_s1;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [OFF_W-1:0]     offset_q;

	logic                 advance;

	assign advance  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || advance;

	// derived configuration
	logic [MORD_W-1:0]    mo;
	logic [7:0]           pow_n;
	logic [POS_W-1:0]     n;
	logic [MAX_SLOTS-1:0] valid_mask;

	assign mo    = (message_order_q > MORD_CAP) ? MORD_CAP : message_order_q;
	assign pow_n = 8'd1 << slot_order_q;
	assign n     = (pow_n > 8'(MAX_SLOTS)) ? POS_W'(MAX_SLOTS) : POS_W'(pow_n);

	always_comb begin
		for (int j = 0; j < MAX_SLOTS; j++) begin
			valid_mask[j] = (8'(j) < pow_n);
		end
	end

	// rotating searches
	logic [MAX_SLOTS-1:0] free_mask, wge, rge;
	logic [POS_W-1:0]     wstart, rstart;
	logic [IDX_W-1:0]     widx, ridx;
	logic                 wfound, rfound;

	assign free_mask = ~occupied_q & valid_mask;
	assign wstart    = (wpos_q >= n) ? '0 : wpos_q;
	assign rstart    = (rpos_q >= n) ? '0 : rpos_q;

	always_comb begin
		for (int j = 0; j < MAX_SLOTS; j++) begin
			wge[j] = (POS_W'(j) >= wstart);
			rge[j] = (POS_W'(j) >= rstart);
		end
	end

	assign wfound = |free_mask;
	assign rfound = |unread_q;
	assign widx = (|(free_mask & wge)) ? first_set(free_mask & wge) : first_set(free_mask);
	assign ridx = (|(unread_q & rge)) ? first_set(unread_q & rge) : first_set(unread_q);

	// ack target
	logic [OFF_W-1:0]     ack_full;
	logic [IDX_W-1:0]     aidx;

	assign ack_full = off_s1 >> mo;
	assign aidx     = ack_full[IDX_W-1:0];

	logic [LEN_W-1:0]     size_limit;
	assign size_limit = LEN_W'(1) << mo;

	// next state and result
	logic [MAX_SLOTS-1:0] occ_d, unr_d;
	logic [CNT_W-1:0]     cnt_d;
	logic [POS_W-1:0]     wpos_d, rpos_d;
	status_t              st_d;
	logic [OFF_W-1:0]     off_d;

	always_comb begin
		occ_d  = occupied_q;
		unr_d  = unread_q;
		cnt_d  = count_q;
		wpos_d = wpos_q;
		rpos_d = rpos_q;
		st_d   = ST_OK;
		off_d  = '0;
		case (mode_t'(mode_s1))
			MODE_ARRIVE: begin
				if (len_s1 > size_limit) begin
					st_d = ST_TOO_LARGE;
				end else if (!wfound) begin
					st_d = ST_NO_SLOT;
				end else begin
					occ_d[widx] = 1'b1;
					unr_d[widx] = 1'b1;
					cnt_d       = count_q + CNT_W'(1);
					wpos_d      = POS_W'(widx) + POS_W'(1);
					off_d       = OFF_W'(widx) << mo;
				end
			end
			MODE_FETCH: begin
				if (count_q == '0 || !rfound) begin
					st_d = ST_NO_MSG;
				end else begin
					unr_d[ridx] = 1'b0;
					cnt_d       = count_q - CNT_W'(1);
					rpos_d      = POS_W'(ridx) + POS_W'(1);
					off_d       = OFF_W'(ridx) << mo;
				end
			end
			MODE_ACK: begin
				if (ack_full >= OFF_W'(n) || !occupied_q[aidx]) begin
					st_d = ST_INVALID;
				end else begin
					occ_d[aidx] = 1'b0;
					if (unread_q[aidx]) begin
						unr_d[aidx] = 1'b0;
						if (count_q != '0) begin
							cnt_d = count_q - CNT_W'(1);
						end
					end
				end
			end
			default: begin
				st_d = ST_INVALID;
			end
		endcase
	end

	// configuration and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_order_q    <= '0;
			message_order_q <= MORD_RESET;
			occupied_q      <= '0;
			unread_q        <= '0;
			count_q         <= '0;
			wpos_q          <= '0;
			rpos_q          <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SLOT_ORDER:    slot_order_q    <= cfg_data[SORD_W-1:0];
				REG_MESSAGE_ORDER: message_order_q <= cfg_data[MORD_W-1:0];
				default: ;
			endcase
			occupied_q <= '0;
			unread_q   <= '0;
			count_q    <= '0;
			wpos_q     <= '0;
			rpos_q     <= '0;
		end else if (advance) begin
			occupied_q <= occ_d;
			unread_q   <= unr_d;
			count_q    <= cnt_d;
			wpos_q     <= wpos_d;
			rpos_q     <= rpos_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			len_s1  <= message_length;
			off_s1  <= message_offset;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= st_d;
			offset_q      <= off_d;
			message_count <= cnt_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = STATUS_W'(status_q);
	assign slot_offset = offset_q;

	// an unread slot is always occupied
	a_unread_in_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(unread_q & ~occupied_q) == '0)
		else $error("unread slot not marked occupied");

	// the count tracks the unread bitmap
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(unread_q)))
		else $error("unread count out of step with bitmap");

	// input stalls only behind a stalled full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a stalled result");

endmodule
